FILE: src/sha256_pkg.sv
// sha-256 hasher package: beat types, constants and a rotate-right function
`timescale 1ns / 1ps
package sha256_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] digest_w0;
		logic [31:0] digest_w1;
		logic [31:0] digest_w2;
		logic [31:0] digest_w3;
		logic [31:0] digest_w4;
		logic [31:0] digest_w5;
		logic [31:0] digest_w6;
		logic [31:0] digest_w7;
	} out_beat_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int unsigned LEN_POS = 56;
	localparam logic [63:0] BLOCK_BITS = 64'd512;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
		ror32 = (x >> n) | (x << (32 - n));
	endfunction

endpackage

FILE: src/sha256_byte_stream_hasher_core.sv
// sha-256 byte-stream hasher: byte buffer, length count and an iterative round unit
`timescale 1ns / 1ps
// Takes one message byte per input beat and hashes it with SHA-256. Bytes shift into a
// 16-word block register at one beat per cycle while not stalled. The beat that
// fills the 64-byte block starts 64 rounds on one shared round unit and a fold step
// that adds the result into the chaining words; in_stall stays high throughout. A beat
// with last set pads the message one byte per cycle (64 minus the bytes held),
// then compresses one block, or two when 56 or more bytes are held (64 more pad bytes
// and another compression); a last beat filling a block has it compressed first. The
// digest then moves into the output register, where it waits until taken; the
// core stays in ST_OUT while an earlier digest waits. The next message then starts.
module sha256_byte_stream_hasher_core
	import sha256_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ROUND = 3'd1;
	localparam logic [2:0] ST_FOLD  = 3'd2;
	localparam logic [2:0] ST_PAD   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [63:0] total_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  rnd_q;
	logic        final_q;
	logic        pad80_q;
	logic        hi_q;
	logic        out_valid_q;
	out_beat_t   out_q;

	logic        accept;
	logic        shift_en;
	logic        inc_bit;
	logic        out_load;
	logic [6:0]  fill_nxt;
	logic [7:0]  len_byte;
	logic [7:0]  pad_byte;
	logic [7:0]  shift_byte;
	logic [31:0] s0, s1, w_new, wt, t1, t2;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	assign inc_bit    = (state_q == ST_PAD) || in_data.byte_valid;
	assign fill_nxt   = {1'b0, fill_q} + {6'd0, inc_bit};
	assign len_byte   = total_q[{3'd7 - fill_q[2:0], 3'd0} +: 8];
	assign shift_en   = (accept && in_data.byte_valid) || (state_q == ST_PAD);
	assign shift_byte = (state_q == ST_PAD) ? pad_byte : in_data.data_byte;

	always_comb begin
		if (pad80_q) begin
			pad_byte = PAD_BYTE;
		end else if (fill_q >= 6'(LEN_POS) && !hi_q) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = 8'h00;
		end
	end

	// message schedule: w_q holds a sliding window of 16 words
	always_comb begin
		s0 = ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		wt = w_q[0];
		t1 = v_q[7] + (ror32(v_q[4], 6) ^ ror32(v_q[4], 11) ^ ror32(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + ROUND_K[rnd_q] + wt;
		t2 = (ror32(v_q[0], 2) ^ ror32(v_q[0], 13) ^ ror32(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else begin
			// bytes enter at the bottom, so the first byte ends up most significant
			if (shift_en) begin
				for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
				w_q[15] <= {w_q[15][23:0], shift_byte};
			end
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			len_q       <= '0;
			total_q     <= '0;
			rnd_q       <= '0;
			final_q     <= 1'b0;
			pad80_q     <= 1'b0;
			hi_q        <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q <= fill_nxt[5:0];
						if (in_data.last) begin
							final_q <= 1'b1;
							pad80_q <= 1'b1;
							total_q <= len_q + {54'd0, fill_nxt, 3'd0};
						end
						if (fill_nxt[6]) begin
							len_q   <= len_q + BLOCK_BITS;
							state_q <= ST_ROUND;
						end else if (in_data.last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					hi_q <= 1'b0;
					if (!final_q) begin
						state_q <= ST_IDLE;
					end else if (pad80_q || hi_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_PAD: begin
					fill_q <= fill_nxt[5:0];
					if (pad80_q) begin
						pad80_q <= 1'b0;
						hi_q    <= (fill_q >= 6'(LEN_POS));
					end
					if (fill_nxt[6]) begin
						state_q <= ST_ROUND;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
						fill_q  <= '0;
						len_q   <= '0;
						final_q <= 1'b0;
						for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_q <= '{h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: test/tb_sha256_byte_stream_hasher_core.sv
// testbench for the sha-256 byte-stream hasher: random messages against a digest predictor
`timescale 1ns / 1ps
module tb_sha256_byte_stream_hasher_core
	import sha256_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 300;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_beat_t out_data;

	sha256_byte_stream_hasher_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	in_beat_t  pending_beats[$];
	out_beat_t expected_digests[$];
	int        error_count = 0;
	int        idle_count = 0;
	bit        hold_off_req;

	// predictor state
	logic [31:0] chain[8];
	logic [7:0]  msg_block[64];
	int          fill;
	logic [63:0] bits_done;

	function automatic logic [31:0] rotr(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_msg_block();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] += v[i];
	endtask

	task automatic reset_hasher();
		for (int i = 0; i < 8; i++)
			chain[i] = INIT_H[i];
		fill = 0;
		bits_done = '0;
	endtask

	task automatic predict_digest(in_beat_t b);
		int pos;
		logic [63:0] total;
		out_beat_t d;
		if (b.byte_valid) begin
			msg_block[fill] = b.data_byte;
			fill++;
			if (fill == 64) begin
				compress_msg_block();
				bits_done += BLOCK_BITS;
				fill = 0;
			end
		end
		if (!b.last)
			return;
		pos = fill;
		total = bits_done + 64'(pos) * 8;
		msg_block[pos++] = PAD_BYTE;
		if (pos > 56) begin
			while (pos < 64)
				msg_block[pos++] = 8'h00;
			compress_msg_block();
			pos = 0;
		end
		while (pos < 56)
			msg_block[pos++] = 8'h00;
		for (int i = 0; i < 8; i++)
			msg_block[56 + i] = total[63 - 8*i -: 8];
		compress_msg_block();
		d = {chain[0], chain[1], chain[2], chain[3], chain[4], chain[5], chain[6], chain[7]};
		expected_digests.push_back(d);
		reset_hasher();
	endtask

	function automatic in_beat_t mk_beat(logic [7:0] d, logic v, logic l);
		in_beat_t b;
		b.data_byte = d;
		b.byte_valid = v;
		b.last = l;
		return b;
	endfunction

	task automatic add_message(int len, bit bare_end, bit noisy);
		for (int i = 0; i < len; i++) begin
			if (noisy && $urandom_range(0, 7) == 0)
				pending_beats.push_back(mk_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0));
			if (!bare_end && i == len - 1)
				pending_beats.push_back(mk_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1));
			else
				pending_beats.push_back(mk_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0));
		end
		if (bare_end || len == 0)
			pending_beats.push_back(mk_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1));
	endtask

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// driver
	int in_wait;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			in_wait <= 0;
		end else if (in_valid && in_stall) begin
		end else if (in_wait > 0) begin
			in_valid <= 1'b0;
			in_wait <= in_wait - 1;
		end else if (pending_beats.size() > 0) begin
			in_valid <= 1'b1;
			in_data <= pending_beats.pop_front();
			in_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// monitor and receiver stall
	int out_wait;
	int hold_count;
	out_beat_t exp_d;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
			out_wait <= 0;
			hold_count <= 0;
			reset_hasher();
		end else begin
			if (in_valid && !in_stall)
				predict_digest(in_data);
			if (out_valid && !out_stall) begin
				if (expected_digests.size() == 0) begin
					$error("digest beat with nothing expected");
					error_count++;
				end else begin
					exp_d = expected_digests.pop_front();
					if (out_data.digest_w0 !== exp_d.digest_w0) begin
						$error("digest_w0 exp %h got %h", exp_d.digest_w0, out_data.digest_w0);
						error_count++;
					end
					if (out_data.digest_w1 !== exp_d.digest_w1) begin
						$error("digest_w1 exp %h got %h", exp_d.digest_w1, out_data.digest_w1);
						error_count++;
					end
					if (out_data.digest_w2 !== exp_d.digest_w2) begin
						$error("digest_w2 exp %h got %h", exp_d.digest_w2, out_data.digest_w2);
						error_count++;
					end
					if (out_data.digest_w3 !== exp_d.digest_w3) begin
						$error("digest_w3 exp %h got %h", exp_d.digest_w3, out_data.digest_w3);
						error_count++;
					end
					if (out_data.digest_w4 !== exp_d.digest_w4) begin
						$error("digest_w4 exp %h got %h", exp_d.digest_w4, out_data.digest_w4);
						error_count++;
					end
					if (out_data.digest_w5 !== exp_d.digest_w5) begin
						$error("digest_w5 exp %h got %h", exp_d.digest_w5, out_data.digest_w5);
						error_count++;
					end
					if (out_data.digest_w6 !== exp_d.digest_w6) begin
						$error("digest_w6 exp %h got %h", exp_d.digest_w6, out_data.digest_w6);
						error_count++;
					end
					if (out_data.digest_w7 !== exp_d.digest_w7) begin
						$error("digest_w7 exp %h got %h", exp_d.digest_w7, out_data.digest_w7);
						error_count++;
					end
				end
			end
			// long hold-off so the block backs up into its input
			if (hold_off_req && hold_count == 0) begin
				hold_count <= 1;
				out_stall <= 1'b1;
			end else if (hold_count > 0) begin
				hold_count <= (hold_count < 400) ? hold_count + 1 : 0;
				out_stall <= 1'b1;
			end else if (out_wait > 0) begin
				out_wait <= out_wait - 1;
				out_stall <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_count > 0)
				idle_count <= 0;
			else
				idle_count <= idle_count + 1;
			if (idle_count >= WATCHDOG_LIMIT) begin
				$display("sha256_byte_stream_hasher_core: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int drained;
		hold_off_req = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty message, idle beats, field extremes
		pending_beats.push_back(mk_beat(8'hff, 1'b0, 1'b0));
		pending_beats.push_back(mk_beat(8'hff, 1'b0, 1'b1));
		pending_beats.push_back(mk_beat(8'h00, 1'b1, 1'b1));
		pending_beats.push_back(mk_beat(8'hff, 1'b1, 1'b0));
		pending_beats.push_back(mk_beat(8'h00, 1'b0, 1'b1));
		pending_beats.push_back(mk_beat(8'h61, 1'b1, 1'b0));
		pending_beats.push_back(mk_beat(8'h62, 1'b1, 1'b0));
		pending_beats.push_back(mk_beat(8'h63, 1'b1, 1'b1));
		add_message(12, 1'b0, 1'b1);

		// messages around the one- and two-block padding boundaries
		add_message(55, 1'b0, 1'b0);
		add_message(56, 1'b0, 1'b0);
		add_message(63, 1'b1, 1'b0);
		add_message(64, 1'b0, 1'b0);
		add_message(64, 1'b1, 1'b0);
		add_message(65, 1'b0, 1'b1);

		// back up the output while the sender keeps offering
		add_message(3, 1'b0, 1'b0);
		add_message(2, 1'b0, 1'b0);
		add_message(130, 1'b0, 1'b0);
		@(posedge clk);
		hold_off_req <= 1'b1;
		@(posedge clk);
		hold_off_req <= 1'b0;

		// random messages, mostly short
		for (int n = 0; n < 12; n++) begin
			if ($urandom_range(0, 9) == 0)
				pending_beats.push_back(mk_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0));
			add_message(($urandom_range(0, 4) == 0) ? $urandom_range(50, 70)
				: $urandom_range(0, 20), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end

		wait (pending_beats.size() == 0 && !in_valid && hold_count == 0);
		drained = 0;
		while (expected_digests.size() > 0 && drained < 100000) begin
			@(posedge clk);
			drained++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_digests.size() == 0)
			$display("sha256_byte_stream_hasher_core: match");
		else
			$display("sha256_byte_stream_hasher_core: mismatch");
		$finish;
	end
endmodule

FILE: filelist.f
src/sha256_pkg.sv
src/sha256_byte_stream_hasher_core.sv
test/tb_sha256_byte_stream_hasher_core.sv
